FILE: hw/rtl/row_shear_linear_resampler_assert.svh
// Assertion macros for the row shear resampler checks.
// Needs a clk and rst in scope where the macros are used.
`ifndef ROW_SHEAR_LINEAR_RESAMPLER_ASSERT_SVH
`define ROW_SHEAR_LINEAR_RESAMPLER_ASSERT_SVH

// Clocked check, off while reset is high.
`define RSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rsr_pkg.sv
// Shared widths and register indexes for the row shear resampler.
// No dependencies.
package rsr_pkg;

  localparam int PIX_W   = 8;
  localparam int IW_W    = 12;
  localparam int STEP_W  = 18;
  localparam int FILL_W  = 8;
  localparam int OFS_W   = 32;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = STEP_W;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_ROW_WIDTH  = 2'd0,
    CFG_SHEAR_STEP = 2'd1,
    CFG_PAD_PIX    = 2'd2
  } cfg_idx_t;

  localparam logic [IW_W-1:0] ROW_WIDTH_RST = 12'd2048;

endpackage

FILE: hw/rtl/row_shear_linear_resampler.sv
// Row shear resampler: shears each row by a growing offset, linear blend.
// Depends on rsr_pkg. One two-bank row store, one write and two reads a cycle.
// A result passes through the stage 1 store read registers, then the output register.
// Throughput: one beat per cycle while the output is not stalled.
// Reset clears config, row state and valid flags; data registers and the row store are not cleared.
module row_shear_linear_resampler #(
  parameter int MAX_WIDTH = 2048,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rsr_pkg::CFG_A_W-1:0]   cfg_addr,
  input  logic [rsr_pkg::CFG_D_W-1:0]   cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rsr_pkg::PIX_W-1:0]     s_tdata,   // [7:0] pixel_in
  input  logic                          s_tuser,   // [0] cmd (1 = flush)
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rsr_pkg::PIX_W-1:0]     m_tdata,   // [7:0] pixel_out
  output logic                          m_tlast    // end_of_row
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int XW = ((AW + FRAC_BITS + 1 > rsr_pkg::OFS_W) ?
                       AW + FRAC_BITS + 1 : rsr_pkg::OFS_W) + 1;
  localparam int QW = XW - FRAC_BITS;
  localparam int SW = rsr_pkg::OFS_W + 1;
  localparam int BW = FRAC_BITS + rsr_pkg::PIX_W + 1;
  localparam int DEPTH = 2 ** (AW + 1);

  // config registers
  logic [rsr_pkg::IW_W-1:0]          row_width;
  logic signed [rsr_pkg::STEP_W-1:0] shear_step;
  logic [rsr_pkg::FILL_W-1:0]        pad_pix;

  // row state
  logic                              write_bank;
  logic [AW-1:0]                     col;
  logic                              have_prev;
  logic signed [rsr_pkg::OFS_W-1:0]  row_offset;

  // stage 1 (store read) and stage 2 (output)
  logic                              s1_valid;
  logic                              s1_fill;
  logic                              s1_last;
  logic [FRAC_BITS-1:0]              s1_frac;
  logic [rsr_pkg::PIX_W-1:0]         s1_p0;
  logic [rsr_pkg::PIX_W-1:0]         s1_p1;

  logic [rsr_pkg::PIX_W-1:0]         mem [0:DEPTH-1];

  logic                              accept;
  logic                              flush;
  logic                              skip;
  logic                              s2_load;
  logic [WW-1:0]                     w_eff;
  logic [AW-1:0]                     col_c;
  logic                              last;
  logic signed [XW-1:0]              xin;
  logic signed [QW-1:0]              x0;
  logic                              fill;
  logic [AW:0]                       waddr;
  logic [AW:0]                       raddr0;
  logic [AW:0]                       raddr1;
  logic signed [SW-1:0]              ofs_sum;
  logic signed [rsr_pkg::OFS_W-1:0]  ofs_next;
  logic [FRAC_BITS:0]                wgt0;
  logic [BW-1:0]                     acc;

  assign flush   = s_tuser;
  assign skip    = flush && !have_prev;
  assign s2_load = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s2_load;
  assign accept  = s_tvalid && s_tready;

  always_comb begin
    if (row_width < rsr_pkg::IW_W'(2)) begin
      w_eff = WW'(2);
    end else if (32'(row_width) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(row_width);
    end
  end

  always_comb begin
    if (WW'(col) >= w_eff) begin
      col_c = AW'(w_eff - WW'(1));
    end else begin
      col_c = col;
    end
  end

  assign last   = (WW'(col_c) + WW'(1)) >= w_eff;
  assign xin    = $signed(XW'({col_c, {FRAC_BITS{1'b0}}})) + XW'(row_offset);
  assign x0     = xin[XW-1:FRAC_BITS];
  assign fill   = x0[QW-1] || (x0 >= $signed(QW'(w_eff - WW'(1))));
  assign waddr  = {write_bank, col_c};
  assign raddr0 = {~write_bank, x0[AW-1:0]};
  assign raddr1 = {~write_bank, x0[AW-1:0] + AW'(1)};

  assign ofs_sum = SW'(row_offset) + SW'(shear_step);
  always_comb begin
    if (ofs_sum[SW-1] != ofs_sum[SW-2]) begin
      ofs_next = ofs_sum[SW-1] ? {1'b1, {(rsr_pkg::OFS_W-1){1'b0}}}
                               : {1'b0, {(rsr_pkg::OFS_W-1){1'b1}}};
    end else begin
      ofs_next = ofs_sum[rsr_pkg::OFS_W-1:0];
    end
  end

  assign wgt0 = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, s1_frac};
  assign acc  = BW'(wgt0) * BW'(s1_p0) + BW'(s1_frac) * BW'(s1_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= rsr_pkg::ROW_WIDTH_RST;
      shear_step <= '0;
      pad_pix    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rsr_pkg::CFG_ROW_WIDTH:  row_width  <= cfg_wdata[rsr_pkg::IW_W-1:0];
        rsr_pkg::CFG_SHEAR_STEP: shear_step <= $signed(cfg_wdata);
        rsr_pkg::CFG_PAD_PIX:    pad_pix    <= cfg_wdata[rsr_pkg::FILL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_bank <= 1'b0;
      col        <= '0;
      have_prev  <= 1'b0;
      row_offset <= '0;
    end else if (accept && !skip) begin
      if (last) begin
        col <= '0;
        if (flush) begin
          have_prev  <= 1'b0;
          row_offset <= '0;
        end else begin
          write_bank <= ~write_bank;
          if (have_prev) begin
            row_offset <= ofs_next;
          end
          have_prev <= 1'b1;
        end
      end else begin
        col <= col_c + AW'(1);
      end
    end
  end

  // row store: one write, two registered reads
  always_ff @(posedge clk) begin
    if (accept && !flush) begin
      mem[waddr] <= s_tdata;
    end
    if (accept) begin
      s1_p0   <= mem[raddr0];
      s1_p1   <= mem[raddr1];
      s1_frac <= xin[FRAC_BITS-1:0];
      s1_fill <= fill;
      s1_last <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= accept && !skip && have_prev;
      end
      if (s2_load) begin
        m_tvalid <= s1_valid;
        if (s1_valid) begin
          m_tdata <= s1_fill ? pad_pix : acc[FRAC_BITS+rsr_pkg::PIX_W-1:FRAC_BITS];
          m_tlast <= s1_last;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/rsr_checker.sv
// Port-level checks for the row shear resampler, bound to the top level.
// Depends on rsr_pkg and row_shear_linear_resampler_assert.svh.
`include "row_shear_linear_resampler_assert.svh"

module rsr_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rsr_pkg::PIX_W-1:0] m_tdata,
  input logic                      m_tlast
);

  property p_out_hold;
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast);
  endproperty

  property p_out_from_input;
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2);
  endproperty

  `RSR_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !m_tvalid, "output valid after reset")

  `RSR_ASSERT(a_out_hold, p_out_hold, "stalled output beat changed")

  `RSR_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with empty output")

  `RSR_ASSERT(a_out_from_input, p_out_from_input, "output beat without input beat")

endmodule

bind row_shear_linear_resampler rsr_checker u_rsr_checker (.*);
